// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rhlc_pkg.sv =====
package rhlc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 16;
  localparam int OPND_W   = SAMPLE_W + 2;
  localparam int ADDEND_W = SAMPLE_W + COEFF_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEFF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF  = 1'd1;

  localparam logic [COEFF_W-1:0] HIGHPASS_COEFF_RST = 16'd59893;
  localparam logic [COEFF_W-1:0] LOWPASS_COEFF_RST  = 16'd31788;

  // operands for one pass through the shared multiply-accumulate unit
  typedef struct packed {
    logic        [COEFF_W-1:0]  coeff;
    logic signed [OPND_W-1:0]   operand;
    logic signed [ADDEND_W-1:0] addend;
  } rhlc_op_t;

endpackage

// ===== sv/rhlc_mac.sv =====
module rhlc_mac (
  input  rhlc_pkg::rhlc_op_t                  op,
  output logic signed [rhlc_pkg::SAMPLE_W-1:0] result
);
  import rhlc_pkg::*;

  localparam int PROD_W = COEFF_W + 1 + OPND_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - COEFF_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [Q_W-1:0]    quot;
  logic                     round_up;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (SAMPLE_W - 1));

  always_comb begin
    prod = $signed({1'b0, op.coeff}) * op.operand;
    sum  = {prod[PROD_W-1], prod}
         + {{(SUM_W - ADDEND_W){op.addend[ADDEND_W-1]}}, op.addend};
    // floor shift, then bump negatives with a nonzero fraction to get truncation
    round_up = sum[SUM_W-1] && (|sum[COEFF_W-1:0]);
    quot = sum[SUM_W-1:COEFF_W] + Q_W'(round_up);
    priority if (quot > Q_MAX) begin
      result = Q_MAX[SAMPLE_W-1:0];
    end else if (quot < Q_MIN) begin
      result = Q_MIN[SAMPLE_W-1:0];
    end else begin
      result = quot[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== sv/rc_highpass_lowpass_cascade_unit.sv =====
// rc high-pass then low-pass filter pair, one signed 16-bit sample per request.
// input channel: sample, restart with in_valid / in_stall; restart (or the
// first sample after reset) reloads both filters so both outputs equal it.
// output channel: filtered_sample (low-pass) and highpass_sample with
// out_valid / out_stall, held in an output register.
// coefficients: cfg_write with cfg_index 0 = high-pass alpha, 1 = low-pass
// alpha, both unsigned Q0.16, to be written by the user only while the block
// is idle, which the block itself does not enforce. one multiply-accumulate
// unit is used twice per sample, first for the high-pass term, then for the
// low-pass term, so a new sample waits for the low-pass step of the last one.
// a new request can be taken in the cycle the previous result is loaded.
// if the receiver stalls, the result waits in the output register and the
// low-pass step holds until it is taken; in_stall stays high meanwhile.
// reset (rst, synchronous) clears filter history, restores default
// coefficients and empties the output register.
`include "assert_macros.svh"

module rc_highpass_lowpass_cascade_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [rhlc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rhlc_pkg::COEFF_W-1:0]           cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rhlc_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                   restart,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rhlc_pkg::SAMPLE_W-1:0]   filtered_sample,
  output logic signed [rhlc_pkg::SAMPLE_W-1:0]   highpass_sample
);
  import rhlc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_HP, ST_LP} state_t;

  state_t                      state;
  logic signed [SAMPLE_W-1:0]  x_reg;
  logic                        first_reg;
  logic signed [SAMPLE_W-1:0]  prev_in;
  logic signed [SAMPLE_W-1:0]  prev_hp;
  logic signed [SAMPLE_W-1:0]  prev_lp;
  logic                        primed;
  logic [COEFF_W-1:0]          hp_coeff;
  logic [COEFF_W-1:0]          lp_coeff;

  logic                        out_free;
  logic                        lp_done;
  logic                        accept;
  rhlc_op_t                    op;
  logic signed [SAMPLE_W-1:0]  mac_result;
  logic signed [SAMPLE_W-1:0]  hp_val;
  logic signed [SAMPLE_W-1:0]  lp_val;

  assign out_free = !out_valid || !out_stall;
  assign lp_done  = (state == ST_LP) && out_free;
  assign in_stall = !((state == ST_IDLE) || lp_done);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (state == ST_LP) begin
      op.coeff   = lp_coeff;
      op.operand = OPND_W'(prev_hp) - OPND_W'(prev_lp);
      op.addend  = {prev_lp, {COEFF_W{1'b0}}};
    end else begin
      op.coeff   = hp_coeff;
      op.operand = OPND_W'(prev_hp) + OPND_W'(x_reg) - OPND_W'(prev_in);
      op.addend  = '0;
    end
  end

  rhlc_mac u_mac (
    .op     (op),
    .result (mac_result)
  );

  assign hp_val = first_reg ? x_reg : mac_result;
  assign lp_val = first_reg ? x_reg : mac_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      primed    <= 1'b0;
      prev_in   <= '0;
      prev_hp   <= '0;
      prev_lp   <= '0;
      hp_coeff  <= HIGHPASS_COEFF_RST;
      lp_coeff  <= LOWPASS_COEFF_RST;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_HIGHPASS_COEFF: hp_coeff <= cfg_data;
          REG_LOWPASS_COEFF:  lp_coeff <= cfg_data;
          default: ;
        endcase
      end
      // a result loaded this cycle keeps out_valid set
      if (out_valid && !out_stall && !lp_done) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            x_reg     <= sample;
            first_reg <= restart || !primed;
            state     <= ST_HP;
          end
        end
        ST_HP: begin
          prev_in <= x_reg;
          prev_hp <= hp_val;
          primed  <= 1'b1;
          state   <= ST_LP;
        end
        ST_LP: begin
          if (out_free) begin
            prev_lp         <= lp_val;
            filtered_sample <= lp_val;
            highpass_sample <= prev_hp;
            out_valid       <= 1'b1;
            if (accept) begin
              x_reg     <= sample;
              first_reg <= restart || !primed;
              state     <= ST_HP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_starts_hp, accept, state == ST_HP, "accepted request did not start")
  `ASSERT_ALWAYS(a_rise_after_lp, !$rose(out_valid) || $past(state == ST_LP), "no low-pass step")
  `ASSERT_NEXT(a_first_passes_input, (state == ST_HP) && first_reg, prev_hp == prev_in, "first")
  `ASSERT_ALWAYS(a_primed_on_output, !out_valid || primed, "result before filter primed")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rhlc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 133;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } filter_request_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic signed [SAMPLE_W-1:0] highpass;
  } filter_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_HIGHPASS_COEFF;
  logic [COEFF_W-1:0]         cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       restart = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic signed [SAMPLE_W-1:0] highpass_sample;

  rc_highpass_lowpass_cascade_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample          (sample),
    .restart         (restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_sample (filtered_sample),
    .highpass_sample (highpass_sample)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter model state
  logic [COEFF_W-1:0]         coef_highpass = HIGHPASS_COEFF_RST;
  logic [COEFF_W-1:0]         coef_lowpass = LOWPASS_COEFF_RST;
  logic signed [SAMPLE_W-1:0] hist_input = '0;
  logic signed [SAMPLE_W-1:0] hist_highpass = '0;
  logic signed [SAMPLE_W-1:0] hist_lowpass = '0;
  logic                       hist_primed = 1'b0;

  filter_request_t pending_requests[$];
  filter_result_t  expected_results[$];
  filter_request_t next_request;
  filter_result_t  want_result;

  int error_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one step of the high-pass then low-pass cascade
  function automatic filter_result_t cascade_predict(input logic signed [SAMPLE_W-1:0] x,
                                                     input logic seg_start);
    longint diff_sum;
    longint hp;
    longint lp;
    filter_result_t r;
    if (seg_start || !hist_primed) begin
      hp = x;
      lp = x;
      hist_primed = 1'b1;
    end else begin
      diff_sum = longint'(hist_highpass) + longint'(x) - longint'(hist_input);
      // division truncates toward zero before the clamp
      hp = clamp16((longint'(coef_highpass) * diff_sum) / 65536);
      lp = clamp16((longint'(hist_lowpass) * 65536 +
                    longint'(coef_lowpass) * (hp - longint'(hist_lowpass))) / 65536);
    end
    hist_input = x;
    hist_highpass = hp[SAMPLE_W-1:0];
    hist_lowpass = lp[SAMPLE_W-1:0];
    r.filtered = lp[SAMPLE_W-1:0];
    r.highpass = hp[SAMPLE_W-1:0];
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, cascade_predict(sample, restart)};
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_request = pending_requests.pop_front();
          in_valid <= 1'b1;
          sample <= next_request.sample;
          restart <= next_request.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with no request pending", results_seen));
        end else begin
          want_result = expected_results.pop_front();
          if (filtered_sample !== want_result.filtered) begin
            report_error($sformatf("result %0d filtered_sample got %0d want %0d",
                                   results_seen, filtered_sample, want_result.filtered));
          end
          if (highpass_sample !== want_result.highpass) begin
            report_error($sformatf("result %0d highpass_sample got %0d want %0d",
                                   results_seen, highpass_sample, want_result.highpass));
          end
        end
        results_seen++;
        // one long hold so the block backs up and stalls its input
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) hold_left--;
      out_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rc_highpass_lowpass_cascade_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_request(input int value, input logic seg_start);
    filter_request_t r;
    r.sample = value[SAMPLE_W-1:0];
    r.restart = seg_start;
    pending_requests = {pending_requests, r};
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_HIGHPASS_COEFF) coef_highpass = value;
    else coef_lowpass = value;
  endtask

  function automatic int pick_sample(input int last);
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (sel < 70) begin
      v = last + int'($urandom_range(4096)) - 2048;
    end else if (sel < 88) begin
      // big steps drive the high-pass stage into saturation
      v = $urandom_range(1) ? last + 9000 : last - 9000;
    end else begin
      case ($urandom_range(3))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        default: v = -1;
      endcase
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    logic [COEFF_W-1:0] hp_set;
    logic [COEFF_W-1:0] lp_set;
    int last;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    sender_idle_pct = 36;
    receiver_idle_pct = 81;
    // first sample after reset without restart, then extremes and restarts
    add_request(32767, 1'b0);
    add_request(-32768, 1'b0);
    add_request(0, 1'b1);
    add_request(-1, 1'b0);
    add_request(1, 1'b1);
    // rising ramp saturates the high-pass stage, then fall back down
    add_request(-32768, 1'b1);
    for (int k = 1; k < 8; k++) add_request(-32768 + 8192 * k, 1'b0);
    add_request(32767, 1'b0);
    for (int k = 1; k <= 8; k++) add_request(32767 - 8192 * k, 1'b0);
    wait_drained();

    last = 0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin hp_set = 16'hFFFF; lp_set = 16'hFFFF; end
        1: begin hp_set = 16'h0000; lp_set = 16'h0000; end
        2: begin hp_set = 16'hFFFF; lp_set = 16'h0000; end
        3: begin hp_set = 16'h0000; lp_set = 16'hFFFF; end
        4: begin hp_set = HIGHPASS_COEFF_RST; lp_set = LOWPASS_COEFF_RST; end
        default: begin
          hp_set = COEFF_W'($urandom_range(65535));
          lp_set = COEFF_W'($urandom_range(65535));
        end
      endcase
      write_coeff(REG_HIGHPASS_COEFF, hp_set);
      write_coeff(REG_LOWPASS_COEFF, lp_set);
      @(negedge clk);
      if (ph < 2) begin
        sender_idle_pct = 36;
        receiver_idle_pct = 81;
      end else if (ph < 4) begin
        sender_idle_pct = 81;
        receiver_idle_pct = 36;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        last = pick_sample(last);
        add_request(last, $urandom_range(99) < 4);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("rc_highpass_lowpass_cascade_unit verification clean");
    end else begin
      $display("rc_highpass_lowpass_cascade_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rhlc_pkg.sv
sv/rhlc_mac.sv
sv/rc_highpass_lowpass_cascade_unit.sv
dv/tb_top.sv
